@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned CapW = 5;
  localparam int unsigned KeyW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW = 32;
  localparam int unsigned StampW = 64;
  localparam int unsigned CapReset = 16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [KeyW-1:0]         req_key;
    logic signed [DataW-1:0] req_value;
  } lfu_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic [KeyW-1:0]         evicted_key;
  } lfu_rsp_t;

  // one memory word: key, data, count and stamp of one slot
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [DataW-1:0]  data;
    logic [CntW-1:0]   cnt;
    logic [StampW-1:0] stamp;
  } lfu_entry_t;

  // "a is a better victim than b": smaller count, then older stamp
  function automatic logic lfu_older(input logic [CntW-1:0] ca, input logic [StampW-1:0] sa,
                                     input logic [CntW-1:0] cb, input logic [StampW-1:0] sb);
    lfu_older = (ca < cb) || ((ca == cb) && (sa < sb));
  endfunction

endpackage

@@ rtl/lfu_mem.sv @@
module lfu_mem
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output lfu_entry_t      rd_data,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  lfu_entry_t      wr_data
);

  lfu_entry_t mem [ENTRIES];

  // single write, single registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lfu_cache_table.sv @@
// LFU key/value cache with LRU tie-break.
// Channels: in_ (request beat: get or put), out_ (one response beat per
// request), cfg_ (capacity write, taken only while idle).
// Each request scans every slot of the entry memory once, one slot per
// cycle through its single read port, then re-reads the target slot and
// writes it back when it updates or inserts an entry.
// The scan finds the key match, the first free slot and the LFU victim
// (smallest count, then oldest stamp, then lowest slot) in one pass.
// The response sits in an output register; a new request is taken while it
// waits, but the next response is not produced until the old one is taken.
// Reset: all slots invalid (valid bits in flops), occupancy and stamp clock
// zero, capacity 16. No clearing pass is needed.
// Capacity above ENTRIES acts as ENTRIES; capacity zero ignores puts.
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lfu_req_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lfu_rsp_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CapW-1:0] cfg_data
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_RDSL = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CapW-1:0]    cap_r;
  logic [ENTRIES-1:0] valid_r;
  logic [OccW-1:0]    occ_r;
  logic [StampW-1:0]  clk_r;
  lfu_req_t           req_r;
  logic [IdxW:0]      ptr_r;     // read address counter
  logic [IdxW-1:0]    cmp_r;     // slot whose data arrives this cycle
  logic               found_r, free_r, vic_r;
  logic [IdxW-1:0]    fidx_r, freeidx_r, vidx_r;
  logic [CntW-1:0]    vcnt_r;
  logic [StampW-1:0]  vstamp_r;
  logic [KeyW-1:0]    vkey_r;
  lfu_rsp_t           rsp_r;
  logic               outv_r;

  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  lfu_entry_t      rd_data, wr_data;

  lfu_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  logic [OccW-1:0] cap_eff;
  assign cap_eff = (32'(cap_r) > ENTRIES) ? OccW'(ENTRIES) : OccW'(cap_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !outv_r;
  assign out_valid = outv_r;
  assign out_data  = rsp_r;

  logic cmp_on;
  assign cmp_on = (state_r == S_SCAN && ptr_r != '0) || state_r == S_LAST;

  logic is_put, do_ins, do_ev, tgt_hit;
  logic [IdxW-1:0] tgt;
  assign is_put  = (req_r.req_type == REQ_PUT);
  assign do_ev   = (occ_r >= cap_eff) && vic_r;
  assign do_ins  = is_put && (cap_eff != '0) && !found_r && (do_ev || free_r);
  assign tgt_hit = found_r && (!is_put || cap_eff != '0);
  assign tgt     = found_r ? fidx_r : (do_ev ? vidx_r : freeidx_r);

  // memory read: scan sweep, then re-read of the target slot
  always_comb begin
    rd_en   = (state_r == S_SCAN) || (state_r == S_RDSL);
    rd_addr = (state_r == S_RDSL) ? tgt : ptr_r[IdxW-1:0];
  end

  logic [CntW-1:0] cnt_inc;
  assign cnt_inc = (rd_data.cnt == '1) ? rd_data.cnt : rd_data.cnt + 1'b1;

  always_comb begin
    wr_en   = (state_r == S_WB) && (tgt_hit || do_ins);
    wr_addr = tgt;
    wr_data = rd_data;
    wr_data.stamp = clk_r + 1'b1;
    if (found_r) begin
      wr_data.cnt = cnt_inc;
      if (is_put) wr_data.data = req_r.req_value;
    end else begin
      wr_data.key  = req_r.req_key;
      wr_data.data = req_r.req_value;
      wr_data.cnt  = CntW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: if (ptr_r == (IdxW+1)'(ENTRIES - 1)) state_nxt = S_LAST;
      S_LAST: state_nxt = S_RDSL;
      S_RDSL: state_nxt = S_WAIT;
      S_WAIT: if (!outv_r || out_ready) state_nxt = S_WB;
      S_WB:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= CapW'(CapReset);
      valid_r <= '0;
      occ_r   <= '0;
      clk_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (outv_r && out_ready) outv_r <= 1'b0;
      if (state_r == S_WB) begin
        outv_r <= 1'b1;
        if (tgt_hit || do_ins) clk_r <= clk_r + 1'b1;
        if (do_ins) begin
          valid_r[tgt] <= 1'b1;
          if (!do_ev) occ_r <= occ_r + 1'b1;
        end
      end
    end
  end

  // scan bookkeeping and response payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r   <= in_data;
      ptr_r   <= '0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      vic_r   <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      ptr_r <= ptr_r + 1'b1;
      cmp_r <= ptr_r[IdxW-1:0];
    end
    if (cmp_on) begin
      if (valid_r[cmp_r]) begin
        if (!found_r && rd_data.key == req_r.req_key) begin
          found_r <= 1'b1;
          fidx_r  <= cmp_r;
        end
        if (!vic_r || lfu_older(rd_data.cnt, rd_data.stamp, vcnt_r, vstamp_r)) begin
          vic_r    <= 1'b1;
          vidx_r   <= cmp_r;
          vcnt_r   <= rd_data.cnt;
          vstamp_r <= rd_data.stamp;
          vkey_r   <= rd_data.key;
        end
      end else if (!free_r) begin
        free_r    <= 1'b1;
        freeidx_r <= cmp_r;
      end
    end
    if (state_r == S_WB) begin
      rsp_r.hit         <= found_r;
      rsp_r.read_value  <= is_put ? '0 : (found_r ? rd_data.data : '1);
      rsp_r.evicted     <= do_ins && do_ev;
      rsp_r.evicted_key <= (do_ins && do_ev) ? vkey_r : '0;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OccW'($countones(valid_r)))
    else $error("occupancy out of step with valid bits");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && outv_r) |-> out_ready)
    else $error("response overwritten");
  a_ev_put: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && rsp_r.evicted) |-> rsp_r.read_value == '0)
    else $error("eviction on a get");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == S_IDLE)
    else $error("config taken while busy");
`endif

endmodule

@@ tb/lfu_cache_checker.sv @@
module lfu_cache_checker
  import lfu_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  lfu_req_t        in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  lfu_rsp_t        out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [CapW-1:0] cfg_data,
  output int              mismatches,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 16;

  // mirror of the cache contents
  logic [CapW-1:0]   cap_q;
  logic              slot_valid[Slots];
  logic [KeyW-1:0]   slot_key[Slots];
  logic [DataW-1:0]  slot_data[Slots];
  logic [CntW-1:0]   slot_cnt[Slots];
  logic [StampW-1:0] slot_stamp[Slots];
  logic [StampW-1:0] stamp_now;
  int                fill;

  lfu_rsp_t expected_rsp[$];

  function automatic void touch(input int s);
    if (slot_cnt[s] != '1) slot_cnt[s] = slot_cnt[s] + 1;
    stamp_now = stamp_now + 1;
    slot_stamp[s] = stamp_now;
  endfunction

  // work out the response of one request and update the mirror
  function automatic lfu_rsp_t lookup_and_update(input lfu_req_t rq);
    lfu_rsp_t r;
    int found;
    int slot;
    int vic;
    int cap;
    r = '0;
    found = -1;
    slot = -1;
    vic = -1;
    cap = (cap_q > Slots) ? Slots : cap_q;
    for (int i = 0; i < Slots; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == rq.req_key) found = i;
    r.hit = (found >= 0);
    if (rq.req_type == REQ_GET) begin
      if (found >= 0) begin
        r.read_value = slot_data[found];
        touch(found);
      end else begin
        r.read_value = -1;
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        slot_data[found] = rq.req_value;
        touch(found);
      end else begin
        if (fill >= cap) begin
          for (int i = 0; i < Slots; i++) begin
            if (!slot_valid[i]) continue;
            if (vic < 0 || slot_cnt[i] < slot_cnt[vic] ||
                (slot_cnt[i] == slot_cnt[vic] && slot_stamp[i] < slot_stamp[vic]))
              vic = i;
          end
          if (vic >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = slot_key[vic];
            slot_valid[vic] = 1'b0;
            if (fill > 0) fill--;
            slot = vic;
          end
        end
        if (slot < 0)
          for (int i = Slots - 1; i >= 0; i--) if (!slot_valid[i]) slot = i;
        if (slot >= 0) begin
          slot_valid[slot] = 1'b1;
          slot_key[slot] = rq.req_key;
          slot_data[slot] = rq.req_value;
          slot_cnt[slot] = 1;
          stamp_now = stamp_now + 1;
          slot_stamp[slot] = stamp_now;
          fill = (fill + 1) & 5'h1f;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lfu_rsp_t want;
    if (!rst_n) begin
      cap_q <= CapW'(CapReset);
      stamp_now = '0;
      fill = 0;
      for (int i = 0; i < Slots; i++) slot_valid[i] = 1'b0;
      expected_rsp.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_q <= cfg_data;
      if (in_valid && in_ready) expected_rsp.push_back(lookup_and_update(in_data));
      // compare each response beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          if (mismatches < 10) $display("unexpected response beat %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.hit !== out_data.hit || want.read_value !== out_data.read_value ||
              want.evicted !== out_data.evicted ||
              want.evicted_key !== out_data.evicted_key) begin
            if (mismatches < 10)
              $display("response mismatch: expected %p got %p", want, out_data);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_rsp.size();
    end
  end

endmodule

@@ tb/lfu_cache_table_tb.sv @@
module lfu_cache_table_tb
  import lfu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  lfu_req_t        in_data;
  logic            out_valid;
  logic            out_ready;
  lfu_rsp_t        out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CapW-1:0] cfg_data;
  int              mismatches;
  int              pending;
  int              cycle_count;
  logic            long_stall;

  lfu_cache_table u_dut (.*);

  lfu_cache_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit: covers every request plus stalls, many times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("lfu_cache_table regression: fail");
        $finish;
      end
    end
  end

  // response side stalls; one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        @(negedge clk);
      end else if (($urandom_range(0, 63) < 8) || (cycle_count % 2000 < 800)) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_req(input logic typ, input logic [KeyW-1:0] k,
                          input logic [DataW-1:0] v);
    in_valid <= 1'b1;
    in_data.req_type <= typ;
    in_data.req_key <= k;
    in_data.req_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // key pool keeps hits frequent; occasional wide keys
  function automatic logic [KeyW-1:0] pick_key(input int pool);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return KeyW'($urandom_range(0, pool));
  endfunction

  initial begin
    logic [CapW-1:0] caps[$];
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    long_stall = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: miss on empty, extremes, saturation-free hits, eviction at capacity 2, capacity 0 and 31
    send_req(REQ_GET, 32'h0, 32'h0);
    send_req(REQ_PUT, 32'hffff_ffff, 32'h7fff_ffff);
    send_req(REQ_PUT, 32'h0, 32'h8000_0000);
    send_req(REQ_GET, 32'hffff_ffff, 32'h0);
    send_req(REQ_GET, 32'h0, 32'hffff_ffff);
    send_req(REQ_PUT, 32'h0, 32'h1234_5678);
    send_req(REQ_GET, 32'haaaa_5555, 32'h0);
    drain();
    write_capacity(5'd2);
    send_req(REQ_PUT, 32'h10, 32'h1);
    send_req(REQ_PUT, 32'h11, 32'h2);
    send_req(REQ_GET, 32'h11, 32'h0);
    send_req(REQ_PUT, 32'h12, 32'h3);
    send_req(REQ_PUT, 32'h13, 32'h4);
    drain();
    write_capacity(5'd0);
    send_req(REQ_PUT, 32'h12, 32'h5);
    send_req(REQ_PUT, 32'h99, 32'h6);
    send_req(REQ_GET, 32'h12, 32'h0);
    drain();
    write_capacity(5'd31);
    send_req(REQ_PUT, 32'h5555_aaaa, 32'h0);
    drain();

    // random phases over several capacities, extremes included
    caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd8, 5'd31, 5'd3, 5'd17, 5'd16, 5'd2};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      for (int n = 0; n < 120; n += burst) begin
        burst = $urandom_range(1, 12);
        if (p == 2 && n == 0) long_stall <= 1'b1;
        for (int b = 0; b < burst; b++) begin
          if (p == 2 && n == 0 && b == 2) long_stall <= 1'b0;
          send_req(1'($urandom_range(0, 1)), pick_key((p % 2) ? 12 : 40), $urandom);
        end
        if ($urandom_range(0, 2) == 0) idle_gap();
        else if (n % 50 == 7) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("lfu_cache_table regression: pass");
    end else begin
      $display("lfu_cache_table regression: fail");
    end
    $finish;
  end

endmodule
